// File: hw/rtl/irpwd_pkg.sv
// Shared types and constants of the IR pulse width decoder.
package irpwd_pkg;

  localparam int unsigned TIME_W = 16;
  localparam int unsigned BITS_W = 4;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [TIME_W-1:0] START_MIN_RST = TIME_W'(120);
  localparam logic [TIME_W-1:0] START_MAX_RST = TIME_W'(150);
  localparam logic [TIME_W-1:0] ONE_MIN_RST = TIME_W'(55);
  localparam logic [TIME_W-1:0] ONE_MAX_RST = TIME_W'(90);
  localparam logic [TIME_W-1:0] ZERO_MIN_RST = TIME_W'(20);
  localparam logic [TIME_W-1:0] ZERO_MAX_RST = TIME_W'(50);
  localparam logic [BITS_W-1:0] FRAME_BITS_RST = BITS_W'(12);

  localparam logic [CODE_W-1:0] CMD_START = 8'h80;
  localparam logic [CODE_W-1:0] CMD_ARM = 8'h81;
  localparam logic [CODE_W-1:0] CMD_STOP = 8'h82;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_MIN = 3'd0,
    REG_START_MAX = 3'd1,
    REG_ONE_MIN = 3'd2,
    REG_ONE_MAX = 3'd3,
    REG_ZERO_MIN = 3'd4,
    REG_ZERO_MAX = 3'd5,
    REG_FRAME_BITS = 3'd6
  } cfg_reg_e;

  // Classified pulse event handed from the front to the back.
  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_START = 3'd1,
    EV_ONE = 3'd2,
    EV_ZERO = 3'd3,
    EV_KEEP = 3'd4
  } ev_kind_e;

  typedef struct packed {
    logic [TIME_W-1:0] start_min;
    logic [TIME_W-1:0] start_max;
    logic [TIME_W-1:0] one_min;
    logic [TIME_W-1:0] one_max;
    logic [TIME_W-1:0] zero_min;
    logic [TIME_W-1:0] zero_max;
    logic [BITS_W-1:0] frame_bits;
  } cfg_t;

endpackage

// File: hw/rtl/ir_pulse_width_decoder_top.sv
// Top level of the IR pulse width decoder with its configuration registers.
// The block decodes a pulse width IR remote frame from a receiver pin sampled once per
// timer tick: each input beat is one tick carrying the pin level, and each input beat
// yields exactly one output beat with the three command lines and, on the tick that
// completes a frame, the 8-bit code. A 16-bit tick counter timestamps every pin change;
// on a rising edge the wrapping time since the previous change is the pulse width. A
// width inside the start window opens a frame, and narrower widths inside a frame set
// or clear the next data bit, LSB first, while a width in neither bit window leaves the
// bit unchanged. After frame_bits bits the frame ends and codes 0x80, 0x81 and 0x82 step
// the start, arm and stop sequence of the lines. The front part classifies each width
// combinationally and a two-entry event queue decouples it from the back part, which
// assembles the frame and updates the command lines into an output register. One beat
// is accepted per clock cycle when the output side keeps up. The edge that accepts a
// beat writes its event into the queue, and the back part loads the result into the
// output register on the edge that pops that event. While the output is stalled the
// queue fills its two entries behind the held result, and then in_stall_o stays high
// until the output moves again.
// Configuration writes are always ready; they must only be issued while no beat is in
// flight. Writes to an index beyond the register list are ignored.
module ir_pulse_width_decoder_top #(
  parameter int unsigned MAX_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               pin_level_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               out_ready_o,
  output logic                               out_toggle_o,
  output logic                               out_run_o,
  output logic                               code_valid_o,
  output logic [irpwd_pkg::CODE_W-1:0]       code_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [irpwd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [irpwd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import irpwd_pkg::*;

  cfg_t     cfg_q;
  logic     in_accept;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  ev_kind_e front_kind;
  ev_kind_e head_kind;

  // Configuration register file; the port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_min <= START_MIN_RST;
      cfg_q.start_max <= START_MAX_RST;
      cfg_q.one_min <= ONE_MIN_RST;
      cfg_q.one_max <= ONE_MAX_RST;
      cfg_q.zero_min <= ZERO_MIN_RST;
      cfg_q.zero_max <= ZERO_MAX_RST;
      cfg_q.frame_bits <= FRAME_BITS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_START_MIN: cfg_q.start_min <= cfg_data_i;
        REG_START_MAX: cfg_q.start_max <= cfg_data_i;
        REG_ONE_MIN: cfg_q.one_min <= cfg_data_i;
        REG_ONE_MAX: cfg_q.one_max <= cfg_data_i;
        REG_ZERO_MIN: cfg_q.zero_min <= cfg_data_i;
        REG_ZERO_MAX: cfg_q.zero_max <= cfg_data_i;
        REG_FRAME_BITS: cfg_q.frame_bits <= cfg_data_i[BITS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Every accepted beat pushes exactly one event, so the queue full flag is the stall.
  assign in_stall_o = q_full;
  assign in_accept = in_valid_i && !in_stall_o;

  irpwd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (in_accept),
    .pin_level_i (pin_level_i),
    .ev_kind_o   (front_kind)
  );

  irpwd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_kind_i (front_kind),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_kind_o (head_kind)
  );

  irpwd_back #(
    .MAX_BITS (MAX_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_bits_i (cfg_q.frame_bits),
    .ev_avail_i   (!q_empty),
    .ev_kind_i    (head_kind),
    .ev_pop_o     (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_ready_o  (out_ready_o),
    .out_toggle_o (out_toggle_o),
    .out_run_o    (out_run_o),
    .code_valid_o (code_valid_o),
    .code_o       (code_o)
  );

`ifndef NO_ASSERTIONS
  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port refused a write");
  a_stall_is_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !in_accept)
    else $error("beat accepted while the event queue is full");
  a_out_backs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !q_pop)
    else $error("event consumed while the output register is held");
`endif

endmodule

// File: hw/rtl/irpwd_front.sv
// Front part: tick counter, edge timestamping and pulse width classification.
module irpwd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  irpwd_pkg::cfg_t     cfg_i,
  input  logic                accept_i,
  input  logic                pin_level_i,
  output irpwd_pkg::ev_kind_e ev_kind_o
);
  import irpwd_pkg::*;

  logic [TIME_W-1:0] tick_q, tick_d;
  logic [TIME_W-1:0] last_edge_q, last_edge_d;
  logic              prev_level_q, prev_level_d;
  logic [TIME_W-1:0] width;
  ev_kind_e          kind;

  always_comb begin
    tick_d = tick_q + TIME_W'(1);
    width = tick_d - last_edge_q;
    last_edge_d = last_edge_q;
    prev_level_d = prev_level_q;
    kind = EV_NONE;
    if (pin_level_i != prev_level_q) begin
      last_edge_d = tick_d;
      prev_level_d = pin_level_i;
      if (pin_level_i) begin
        priority if (width > cfg_i.start_min) begin
          kind = (width < cfg_i.start_max) ? EV_START : EV_NONE;
        end else if (width > cfg_i.one_min && width < cfg_i.one_max) begin
          kind = EV_ONE;
        end else if (width < cfg_i.zero_max && width > cfg_i.zero_min) begin
          kind = EV_ZERO;
        end else begin
          kind = EV_KEEP;
        end
      end
    end
  end

  assign ev_kind_o = kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      last_edge_q <= '0;
      prev_level_q <= 1'b1;
    end else if (accept_i) begin
      tick_q <= tick_d;
      last_edge_q <= last_edge_d;
      prev_level_q <= prev_level_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_tick_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> tick_q == $past(tick_q) + TIME_W'(1))
    else $error("tick counter did not advance on an accepted beat");
  a_tick_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(tick_q) && $stable(last_edge_q))
    else $error("timing state changed without an accepted beat");
  a_edge_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (pin_level_i != prev_level_q) |=> last_edge_q == tick_q)
    else $error("edge was not timestamped with the current tick");
`endif

endmodule

// File: hw/rtl/irpwd_queue.sv
// Two-entry queue of classified events between the front and the back.
module irpwd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  irpwd_pkg::ev_kind_e push_kind_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output irpwd_pkg::ev_kind_e head_kind_o
);
  import irpwd_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  ev_kind_e           entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;

  assign full_o = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_kind_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_kind_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("queue fill count out of step");
`endif

endmodule

// File: hw/rtl/irpwd_back.sv
// Back part: frame assembly, command sequencing and the output register.
module irpwd_back #(
  parameter int unsigned MAX_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [irpwd_pkg::BITS_W-1:0]        frame_bits_i,
  input  logic                                ev_avail_i,
  input  irpwd_pkg::ev_kind_e                 ev_kind_i,
  output logic                                ev_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                out_ready_o,
  output logic                                out_toggle_o,
  output logic                                out_run_o,
  output logic                                code_valid_o,
  output logic [irpwd_pkg::CODE_W-1:0]        code_o
);
  import irpwd_pkg::*;

  logic                    in_frame_q, in_frame_d;
  logic [BITS_W-1:0]       bit_idx_q, bit_idx_d;
  logic [MAX_BITS-1:0]     word_q, word_d;
  logic                    started_q, started_d;
  logic                    armed_q, armed_d;
  logic                    ready_q, ready_d;
  logic                    toggle_q, toggle_d;
  logic                    run_q, run_d;
  logic                    valid_q;
  logic                    code_valid_q, code_valid_d;
  logic [CODE_W-1:0]       code_q, code_d;
  logic [BITS_W-1:0]       idx_next;
  logic [MAX_BITS+CODE_W-1:0] word_ext;
  logic [MAX_BITS-1:0]     word_bits;

  assign ev_pop_o = ev_avail_i && (!valid_q || !out_stall_i);

  always_comb begin
    in_frame_d = in_frame_q;
    bit_idx_d = bit_idx_q;
    word_d = word_q;
    started_d = started_q;
    armed_d = armed_q;
    ready_d = ready_q;
    toggle_d = toggle_q;
    run_d = run_q;
    code_valid_d = 1'b0;
    code_d = '0;
    idx_next = bit_idx_q + BITS_W'(1);
    word_bits = word_q;
    for (int i = 0; i < int'(MAX_BITS); i++) begin
      if (bit_idx_q == BITS_W'(i)) begin
        if (ev_kind_i == EV_ONE) begin
          word_bits[i] = 1'b1;
        end else if (ev_kind_i == EV_ZERO) begin
          word_bits[i] = 1'b0;
        end
      end
    end
    word_ext = {{CODE_W{1'b0}}, word_bits};
    unique case (ev_kind_i)
      EV_START: begin
        in_frame_d = 1'b1;
        bit_idx_d = '0;
        word_d = '0;
      end
      EV_ONE, EV_ZERO, EV_KEEP: begin
        if (in_frame_q) begin
          word_d = word_bits;
          bit_idx_d = idx_next;
          if (idx_next >= frame_bits_i || idx_next == '0) begin
            code_d = word_ext[CODE_W-1:0];
            code_valid_d = 1'b1;
            word_d = '0;
            bit_idx_d = '0;
            in_frame_d = 1'b0;
            if (code_d == CMD_START) begin
              toggle_d = !toggle_q;
              started_d = 1'b1;
              run_d = 1'b0;
            end else if (code_d == CMD_ARM) begin
              if (started_q) begin
                run_d = 1'b1;
                ready_d = 1'b1;
                toggle_d = 1'b0;
                armed_d = 1'b1;
              end
            end else if (code_d == CMD_STOP) begin
              if (armed_q) begin
                run_d = 1'b0;
                ready_d = 1'b0;
                started_d = 1'b0;
                armed_d = 1'b0;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      bit_idx_q <= '0;
      word_q <= '0;
      started_q <= 1'b0;
      armed_q <= 1'b0;
      ready_q <= 1'b0;
      toggle_q <= 1'b0;
      run_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (ev_pop_o) begin
        in_frame_q <= in_frame_d;
        bit_idx_q <= bit_idx_d;
        word_q <= word_d;
        started_q <= started_d;
        armed_q <= armed_d;
        ready_q <= ready_d;
        toggle_q <= toggle_d;
        run_q <= run_d;
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_pop_o) begin
      code_valid_q <= code_valid_d;
      code_q <= code_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_ready_o = ready_q;
  assign out_toggle_o = toggle_q;
  assign out_run_o = run_q;
  assign code_valid_o = code_valid_q;
  assign code_o = code_q;

`ifndef NO_ASSERTIONS
  a_arm_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> started_q)
    else $error("armed without a preceding start");
  a_ready_is_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q == armed_q)
    else $error("ready line out of step with the armed flag");
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !code_valid_q |-> code_q == '0)
    else $error("code nonzero on a beat without a completed frame");
  a_idle_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> bit_idx_q == '0 && word_q == '0)
    else $error("frame state left over outside a frame");
`endif

endmodule
